// ===== rtl/gfta_pkg.sv =====
// shared types and constants for the gop frame type assigner
package gfta_pkg;

    localparam int ORDER_W    = 16;
    localparam int GOP_W      = 11;
    localparam int IDR_INT_W  = 8;
    localparam int RD_W       = 5;
    localparam int TOTAL_W    = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PERIOD_W   = GOP_W + IDR_INT_W;
    localparam int POS_W      = PERIOD_W + 1;
    localparam int CNT_W      = 4;

    localparam logic [KIND_W-1:0] KIND_I = 2'd0;
    localparam logic [KIND_W-1:0] KIND_P = 2'd1;
    localparam logic [KIND_W-1:0] KIND_B = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GOP_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDR_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BREF_ENABLE  = 3'd4;

    localparam logic [GOP_W-1:0]     GOP_SIZE_RST     = 11'd32;
    localparam logic [IDR_INT_W-1:0] IDR_INTERVAL_RST = 8'd0;
    localparam logic [RD_W-1:0]      REF_DISTANCE_RST = 5'd1;
    localparam logic [TOTAL_W-1:0]   TOTAL_FRAMES_RST = 16'hFFFF;

    // last step index of each serial modulo pass
    localparam logic [CNT_W-1:0] GOP_MOD_LAST = CNT_W'(ORDER_W - 1);
    localparam logic [CNT_W-1:0] RD_MOD_LAST  = CNT_W'(GOP_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_GOP,
        ST_SETUP_RD,
        ST_MOD_RD,
        ST_CLASSIFY,
        ST_PYRAMID,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic setup_rd;
        logic classify;
        logic pyr_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic pyr_done;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/gfta_ctrl.sv =====
// controller state machine sequencing the modulo passes, classification and pyramid walk
module gfta_ctrl
    import gfta_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              accept;

    assign accept = i_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_MOD_GOP;
            end
            ST_MOD_GOP: begin
                if (r_cnt == GOP_MOD_LAST) n_state = ST_SETUP_RD;
            end
            ST_SETUP_RD: n_state = ST_MOD_RD;
            ST_MOD_RD: begin
                if (r_cnt == RD_MOD_LAST) n_state = ST_CLASSIFY;
            end
            ST_CLASSIFY: n_state = ST_PYRAMID;
            ST_PYRAMID: begin
                if (i_sts.pyr_done) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        n_cnt   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = accept;
            end
            ST_MOD_GOP: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt != GOP_MOD_LAST) n_cnt = r_cnt + 1'b1;
            end
            ST_SETUP_RD: o_cmd.setup_rd = 1'b1;
            ST_MOD_RD: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt != RD_MOD_LAST) n_cnt = r_cnt + 1'b1;
            end
            ST_CLASSIFY: o_cmd.classify = 1'b1;
            ST_PYRAMID:  o_cmd.pyr_step = 1'b1;
            ST_FINISH:   o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/gfta_dp.sv =====
// datapath: configuration registers, serial modulo unit, classifier, pyramid walk, output register
module gfta_dp
    import gfta_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ORDER_W-1:0]    i_frame_order,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ORDER_W-1:0]    o_display_order,
    output logic [KIND_W-1:0]     o_frame_kind,
    output logic                  o_is_reference,
    output logic                  o_is_idr
);

    logic [GOP_W-1:0]     r_gop_size;
    logic [IDR_INT_W-1:0] r_idr_interval;
    logic [RD_W-1:0]      r_ref_distance;
    logic [TOTAL_W-1:0]   r_total_frames;
    logic                 r_bref_enable;

    logic [ORDER_W-1:0]      r_last_idr;
    logic [ORDER_W-1:0]      r_order;
    logic [ORDER_W-1:0]      r_dist;
    logic [PERIOD_W-1:0]     r_idr_period;
    logic signed [POS_W-1:0] r_to_end;
    logic signed [POS_W-1:0] r_end_pos;
    logic signed [POS_W-1:0] r_left_base;

    logic [ORDER_W-1:0] r_dvd;
    logic [GOP_W-1:0]   r_rem;
    logic [GOP_W-1:0]   r_div;
    logic [GOP_W-1:0]   r_m;

    logic [KIND_W-1:0] r_kind;
    logic              r_is_ref;
    logic              r_is_idr;
    logic              r_need_pyr;
    logic [RD_W-1:0]   r_bpos;
    logic [RD_W-1:0]   r_span;

    logic              r_out_valid;
    logic [ORDER_W-1:0] r_out_order;
    logic [KIND_W-1:0] r_out_kind;
    logic              r_out_ref;
    logic              r_out_idr;

    logic [GOP_W-1:0]        gop_eff;
    logic [RD_W-1:0]         rd_eff;
    logic [ORDER_W-1:0]      dist_new;
    logic [PERIOD_W-1:0]     period_prod;
    logic [GOP_W:0]          div_sh;
    logic [GOP_W:0]          div_sub;
    logic [GOP_W-1:0]        n_rem;
    logic signed [POS_W-1:0] period_ext;
    logic signed [POS_W-1:0] n_end_pos;
    logic signed [POS_W-1:0] dist_ext;
    logic signed [POS_W-1:0] left;
    logic signed [POS_W-1:0] rd_ext;
    logic [RD_W-1:0]         rem_low;
    logic [RD_W-1:0]         span_init;
    logic                    idr_hit;
    logic                    last_before_end;
    logic                    pyr_go;
    logic [RD_W:0]           mid_sum;
    logic [RD_W-1:0]         mid;
    logic                    pyr_hit;
    logic                    out_take;

    assign gop_eff  = (r_gop_size == '0) ? GOP_W'(1) : r_gop_size;
    assign rd_eff   = (r_ref_distance == '0) ? RD_W'(1) : r_ref_distance;
    assign dist_new = i_frame_order - r_last_idr;
    assign period_prod = {{GOP_W{1'b0}}, r_idr_interval} * {{IDR_INT_W{1'b0}}, gop_eff};

    // one restoring step of the shared modulo unit
    assign div_sh  = {r_rem, r_dvd[ORDER_W-1]};
    assign div_sub = div_sh - {1'b0, r_div};
    assign n_rem   = (div_sh >= {1'b0, r_div}) ? div_sub[GOP_W-1:0] : div_sh[GOP_W-1:0];

    assign period_ext = signed'({1'b0, r_idr_period});
    assign n_end_pos  = ((r_idr_interval != '0) && (period_ext < r_to_end)) ?
                        period_ext : r_to_end;

    assign dist_ext        = signed'({{(POS_W-ORDER_W){1'b0}}, r_dist});
    assign idr_hit         = (r_dist == '0) ||
                             ((r_idr_interval != '0) &&
                              ({{(PERIOD_W-ORDER_W){1'b0}}, r_dist} == r_idr_period));
    assign last_before_end = (dist_ext + POS_W'(1)) == r_end_pos;
    assign rem_low         = r_rem[RD_W-1:0];
    assign left            = r_left_base + signed'({{(POS_W-RD_W){1'b0}}, rem_low});
    assign rd_ext          = signed'({{(POS_W-RD_W){1'b0}}, rd_eff});
    assign span_init       = (left > rd_ext) ? rd_eff :
                             (left > POS_W'(3)) ? (left[RD_W-1:0] - RD_W'(1)) : '0;

    assign pyr_go  = r_need_pyr && (r_bpos > RD_W'(1)) && (r_span > RD_W'(2));
    assign mid_sum = {1'b0, r_span} + (RD_W+1)'(1);
    assign mid     = mid_sum[RD_W:1];
    assign pyr_hit = (r_bpos == mid);

    assign out_take       = r_out_valid && i_ready;
    assign o_sts.pyr_done = !pyr_go || pyr_hit;
    assign o_sts.out_free = !r_out_valid || i_ready;

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gop_size     <= GOP_SIZE_RST;
            r_idr_interval <= IDR_INTERVAL_RST;
            r_ref_distance <= REF_DISTANCE_RST;
            r_total_frames <= TOTAL_FRAMES_RST;
            r_bref_enable  <= 1'b0;
            r_last_idr     <= '0;
            r_out_valid    <= 1'b0;
            r_need_pyr     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GOP_SIZE:     r_gop_size     <= i_cfg_data[GOP_W-1:0];
                    CFG_IDR_INTERVAL: r_idr_interval <= i_cfg_data[IDR_INT_W-1:0];
                    CFG_REF_DISTANCE: r_ref_distance <= i_cfg_data[RD_W-1:0];
                    CFG_TOTAL_FRAMES: r_total_frames <= i_cfg_data[TOTAL_W-1:0];
                    CFG_BREF_ENABLE:  r_bref_enable  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.classify) begin
                r_need_pyr <= !idr_hit && (r_m != '0) && (rem_low != '0) &&
                              !last_before_end && r_bref_enable;
                if (idr_hit) begin
                    r_last_idr <= r_order;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_end_pos   <= n_end_pos;
        r_left_base <= r_end_pos - dist_ext;
        if (i_cmd.load) begin
            r_order      <= i_frame_order;
            r_dist       <= dist_new;
            r_idr_period <= period_prod;
            r_to_end     <= signed'({{(POS_W-TOTAL_W){1'b0}}, r_total_frames}) -
                            signed'({{(POS_W-ORDER_W){1'b0}}, r_last_idr});
            r_dvd        <= dist_new;
            r_rem        <= '0;
            r_div        <= gop_eff;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[ORDER_W-2:0], 1'b0};
        end
        if (i_cmd.setup_rd) begin
            r_m   <= r_rem;
            r_dvd <= {r_rem, {(ORDER_W-GOP_W){1'b0}}};
            r_rem <= '0;
            r_div <= {{(GOP_W-RD_W){1'b0}}, rd_eff};
        end
        if (i_cmd.classify) begin
            r_is_idr <= idr_hit;
            r_bpos   <= rem_low;
            r_span   <= span_init;
            if (idr_hit) begin
                r_kind   <= KIND_I;
                r_is_ref <= 1'b1;
            end else if (r_m == '0) begin
                r_kind   <= KIND_I;
                r_is_ref <= 1'b1;
            end else if ((rem_low == '0) || last_before_end) begin
                r_kind   <= KIND_P;
                r_is_ref <= 1'b1;
            end else begin
                r_kind   <= KIND_B;
                r_is_ref <= 1'b0;
            end
        end
        if (i_cmd.pyr_step && pyr_go) begin
            if (pyr_hit) begin
                r_is_ref <= 1'b1;
            end else if (r_bpos > mid) begin
                r_bpos <= r_bpos - mid;
                r_span <= r_span - mid;
            end else begin
                r_span <= mid;
            end
        end
        if (i_cmd.out_load) begin
            r_out_order <= r_order;
            r_out_kind  <= r_kind;
            r_out_ref   <= r_is_ref;
            r_out_idr   <= r_is_idr;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_display_order = r_out_order;
    assign o_frame_kind    = r_out_kind;
    assign o_is_reference  = r_out_ref;
    assign o_is_idr        = r_out_idr;

endmodule

// ===== rtl/gop_frame_type_assigner.sv =====
// top level of the gop frame type assigner
// an item passes the gop modulo pass (16 steps), a setup step, the reference-distance modulo pass (11 steps),
// classification, the pyramid walk and the output register, in that order
// the next item is taken while a result waits in the output register
// reset: synchronous active-low i_rst_n restores register defaults and a last idr position of 0
module gop_frame_type_assigner
    import gfta_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ORDER_W-1:0]    i_frame_order,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ORDER_W-1:0]    o_display_order,
    output logic [KIND_W-1:0]     o_frame_kind,
    output logic                  o_is_reference,
    output logic                  o_is_idr
);

    t_cmd cmd;
    t_sts sts;

    gfta_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gfta_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_frame_order   (i_frame_order),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_display_order (o_display_order),
        .o_frame_kind    (o_frame_kind),
        .o_is_reference  (o_is_reference),
        .o_is_idr        (o_is_idr)
    );

endmodule

// ===== test/tb_gop_frame_type_assigner.sv =====
// self-checking testbench for the gop frame type assigner: predicted frame types over frame runs
module tb_gop_frame_type_assigner
    import gfta_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int ITEM_TARGET = 1425;

    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [KIND_W-1:0]  kind;
        logic               is_ref;
        logic               is_idr;
    } t_frame_verdict;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [ORDER_W-1:0]    i_frame_order = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [ORDER_W-1:0]    o_display_order;
    logic [KIND_W-1:0]     o_frame_kind;
    logic                  o_is_reference;
    logic                  o_is_idr;

    // predictor copy of the registers and the idr position
    logic [GOP_W-1:0]     cfg_gop = GOP_SIZE_RST;
    logic [IDR_INT_W-1:0] cfg_idr_int = IDR_INTERVAL_RST;
    logic [RD_W-1:0]      cfg_rd = REF_DISTANCE_RST;
    logic [TOTAL_W-1:0]   cfg_total = TOTAL_FRAMES_RST;
    logic                 cfg_bref = 1'b0;
    logic [ORDER_W-1:0]   cfg_last_idr = '0;

    logic [ORDER_W-1:0] frames_to_send[$];
    t_frame_verdict     pending_verdicts[$];

    int  frames_queued = 0;
    int  frames_taken = 0;
    int  mismatches = 0;
    int  settings_used = 0;
    int  idr_seen = 0, i_seen = 0, p_seen = 0, b_seen = 0, bref_seen = 0;
    int  quiet_cycles = 0;
    int  tx_gap = 0, rx_gap = 0, hold_left = 0;
    bit  item_taken = 1'b0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0, hold_done = 1'b0;

    gop_frame_type_assigner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_frame_order   (i_frame_order),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_display_order (o_display_order),
        .o_frame_kind    (o_frame_kind),
        .o_is_reference  (o_is_reference),
        .o_is_idr        (o_is_idr)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic pyramid_b_ref(input int bpos, input int span);
        int mid;
        while (bpos > 1 && span > 2) begin
            mid = (span + 1) / 2;
            if (bpos == mid) return 1'b1;
            if (bpos > mid) begin
                bpos -= mid;
                span -= mid;
            end else begin
                span = mid;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_frame_verdict assign_frame_type(input logic [ORDER_W-1:0] order);
        t_frame_verdict v;
        logic [ORDER_W-1:0] gap;
        int gop, rd, frame_dist, period, end_pos, pos, bpos, left, span;
        gop = (cfg_gop == 0) ? 1 : int'(cfg_gop);
        rd = (cfg_rd == 0) ? 1 : int'(cfg_rd);
        gap = order - cfg_last_idr;
        frame_dist = int'(gap);
        period = int'(cfg_idr_int) * gop;
        end_pos = int'(cfg_total) - int'(cfg_last_idr);
        if (cfg_idr_int != 0 && period < end_pos) end_pos = period;
        pos = frame_dist % gop;
        v.order = order;
        v.kind = KIND_B;
        v.is_ref = 1'b0;
        v.is_idr = 1'b0;
        if (frame_dist == 0 || (cfg_idr_int != 0 && frame_dist == period)) begin
            v.kind = KIND_I;
            v.is_ref = 1'b1;
            v.is_idr = 1'b1;
            cfg_last_idr = order;
        end else if (pos == 0) begin
            v.kind = KIND_I;
            v.is_ref = 1'b1;
        end else if (pos % rd == 0 || frame_dist + 1 == end_pos) begin
            // last frame before the next idr or the sequence end is forced to p
            v.kind = KIND_P;
            v.is_ref = 1'b1;
        end else if (cfg_bref) begin
            bpos = pos % rd;
            left = end_pos - (frame_dist - bpos);
            span = (left > rd) ? rd : left - 1;
            v.is_ref = pyramid_b_ref(bpos, span);
        end
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_GOP_SIZE:     cfg_gop = val[GOP_W-1:0];
            CFG_IDR_INTERVAL: cfg_idr_int = val[IDR_INT_W-1:0];
            CFG_REF_DISTANCE: cfg_rd = val[RD_W-1:0];
            CFG_TOTAL_FRAMES: cfg_total = val[TOTAL_W-1:0];
            CFG_BREF_ENABLE:  cfg_bref = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_frame(input logic [ORDER_W-1:0] f);
        frames_to_send = {frames_to_send, f};
        frames_queued++;
    endtask

    // wait until every item has gone in and every verdict has come out
    task automatic drain();
        do @(negedge i_clk);
        while (frames_to_send.size() != 0 || frames_taken != frames_queued ||
               pending_verdicts.size() != 0);
    endtask

    // a run from the current idr position, with skips and stray frames mixed in
    task automatic send_run(input int len, input int noise_pct);
        logic [ORDER_W-1:0] f;
        f = cfg_last_idr;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                queue_frame(ORDER_W'($urandom));
            end else begin
                queue_frame(f);
                f = f + (($urandom_range(0, 19) == 0) ? 16'd2 : 16'd1);
            end
        end
    endtask

    task automatic pick_settings(input int len);
        logic [15:0] gop_v, rd_v, idr_v, tot_v;
        case ($urandom_range(0, 11))
            0: gop_v = 16'd0;
            1: gop_v = 16'd1024;
            2: gop_v = 16'd2047;
            3, 4: gop_v = 16'($urandom_range(17, 64));
            default: gop_v = 16'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 9))
            0: rd_v = 16'd0;
            1: rd_v = 16'($urandom_range(17, 31));
            2: rd_v = 16'd16;
            default: rd_v = 16'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: idr_v = 16'd0;
            3: idr_v = 16'd255;
            default: idr_v = 16'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 7))
            0: tot_v = 16'hFFFF;
            1: tot_v = 16'd1;
            2: tot_v = 16'($urandom);
            3: tot_v = cfg_last_idr - 16'($urandom_range(1, 50));
            default: tot_v = cfg_last_idr + 16'($urandom_range(1, len + 4));
        endcase
        write_reg(CFG_GOP_SIZE, {5'($urandom), gop_v[GOP_W-1:0]});
        write_reg(CFG_IDR_INTERVAL, {8'($urandom), idr_v[IDR_INT_W-1:0]});
        write_reg(CFG_REF_DISTANCE, {11'($urandom), rd_v[RD_W-1:0]});
        write_reg(CFG_TOTAL_FRAMES, tot_v);
        write_reg(CFG_BREF_ENABLE, 16'($urandom));
        settings_used++;
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || item_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (frames_to_send.size() == 0) begin
                i_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                tx_gap = $urandom_range(0, 2);
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_frame_order <= frames_to_send.pop_front();
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_gap = $urandom_range(0, 2);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // predict on input, compare on output, watchdog
    always @(posedge i_clk) begin
        t_frame_verdict want;
        t_frame_verdict fresh;
        if (!i_rst_n) begin
            item_taken = 1'b0;
            quiet_cycles = 0;
        end else begin
            item_taken = i_valid && o_ready;
            if (o_valid && i_ready) begin
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected item: display_order %0d", o_display_order);
                    mismatches++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_display_order !== want.order) begin
                        $error("display_order: expected %0d, got %0d", want.order,
                               o_display_order);
                        mismatches++;
                    end
                    if (o_frame_kind !== want.kind) begin
                        $error("frame_kind: expected %0d, got %0d", want.kind, o_frame_kind);
                        mismatches++;
                    end
                    if (o_is_reference !== want.is_ref) begin
                        $error("is_reference: expected %0d, got %0d", want.is_ref,
                               o_is_reference);
                        mismatches++;
                    end
                    if (o_is_idr !== want.is_idr) begin
                        $error("is_idr: expected %0d, got %0d", want.is_idr, o_is_idr);
                        mismatches++;
                    end
                    if (want.is_idr) idr_seen++;
                    else if (want.kind == KIND_I) i_seen++;
                    else if (want.kind == KIND_P) p_seen++;
                    else begin
                        b_seen++;
                        if (want.is_ref) bref_seen++;
                    end
                end
            end
            if (item_taken) begin
                fresh = assign_frame_type(i_frame_order);
                pending_verdicts = {pending_verdicts, fresh};
                frames_taken++;
            end
            if (item_taken || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("no handshake for %0d cycles, %0d verdicts outstanding",
                         quiet_cycles, pending_verdicts.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int len;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: field extremes, wrap of the distance, return to the idr frame
        queue_frame(16'd0);
        queue_frame(16'd1);
        queue_frame(16'd32);
        queue_frame(16'hFFFE);
        queue_frame(16'hFFFF);
        queue_frame(16'd0);
        drain();

        // zero gop size and zero reference distance fall back to one
        write_reg(CFG_GOP_SIZE, 16'd0);
        write_reg(CFG_REF_DISTANCE, 16'd0);
        write_reg(CFG_SPARE, 16'hFFFF);
        queue_frame(16'd5);
        queue_frame(16'd6);
        drain();

        // periodic idr, forced p before it, pyramid b, then a frame before the idr
        write_reg(CFG_GOP_SIZE, 16'd8);
        write_reg(CFG_REF_DISTANCE, 16'd4);
        write_reg(CFG_IDR_INTERVAL, 16'd2);
        write_reg(CFG_TOTAL_FRAMES, 16'd20);
        write_reg(CFG_BREF_ENABLE, 16'd1);
        for (int k = 0; k <= 16; k++) queue_frame(ORDER_W'(k));
        queue_frame(16'd3);
        drain();

        // high values in every register, with the idr interval and total frames at their maximum
        write_reg(CFG_GOP_SIZE, 16'd1024);
        write_reg(CFG_IDR_INTERVAL, 16'd255);
        write_reg(CFG_REF_DISTANCE, 16'd16);
        write_reg(CFG_TOTAL_FRAMES, 16'hFFFF);
        write_reg(CFG_BREF_ENABLE, 16'd1);
        send_run(40, 0);
        drain();

        // low end: gop size and idr interval of one, sequence of one frame
        write_reg(CFG_GOP_SIZE, 16'd1);
        write_reg(CFG_IDR_INTERVAL, 16'd1);
        write_reg(CFG_REF_DISTANCE, 16'd1);
        write_reg(CFG_TOTAL_FRAMES, 16'd1);
        write_reg(CFG_BREF_ENABLE, 16'd0);
        send_run(20, 0);
        settings_used += 5;

        while (frames_queued < ITEM_TARGET) begin
            drain();
            len = $urandom_range(20, 80);
            idle_on = (frames_queued < ITEM_TARGET - 250) && ($urandom_range(0, 3) != 0);
            if (settings_used == 8) len = 80;
            pick_settings(len);
            send_run(len, 8);
            if (settings_used == 8) hold_req = 1'b1;
        end
        drain();
        repeat (60) @(negedge i_clk);

        $display("checked %0d frames over %0d register settings with one long output hold",
                 frames_taken, settings_used);
        $display("verdicts: %0d idr, %0d i, %0d p, %0d b of which %0d reference",
                 idr_seen, i_seen, p_seen, b_seen, bref_seen);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gfta_pkg.sv
rtl/gfta_ctrl.sv
rtl/gfta_dp.sv
rtl/gop_frame_type_assigner.sv
test/tb_gop_frame_type_assigner.sv
